@@ hdl/tcc_pkg.sv @@
package tcc_pkg;

    // Field and datapath widths
    localparam int FIELD_W = 16;
    localparam int SMP_W   = 17;
    localparam int ANG_W   = 16;
    localparam int SQ_W    = 34;
    localparam int ROOT_W  = 17;
    localparam int VEC_W   = 52;
    localparam int NORM_W  = 54;
    localparam int CORD_W  = 36;
    localparam int ROT_W   = 34;
    localparam int ROT_Z_W = 33;
    localparam int TAB_LEN = 24;

    localparam logic [31:0] PI_Z32 = 32'h8000_0000;
    localparam logic signed [ROT_W-1:0] INV_GAIN = 34'sh0_26DD_3B6A;

    typedef logic signed [SMP_W-1:0] smp_t;
    typedef logic signed [ANG_W-1:0] bam_t;

    typedef struct packed {
        smp_t ax;
        smp_t ay;
        smp_t az;
        smp_t mx;
        smp_t my;
        smp_t mz;
    } imu_t;

    // atan(2^-i), 2^31 = pi
    function automatic logic [31:0] atan_entry(input int idx);
        logic [31:0] v;
        begin
            case (idx)
                0:       v = 32'h2000_0000;
                1:       v = 32'h12E4_051E;
                2:       v = 32'h09FB_385B;
                3:       v = 32'h0511_11D4;
                4:       v = 32'h028B_0D43;
                5:       v = 32'h0145_D7E1;
                6:       v = 32'h00A2_F61E;
                7:       v = 32'h0051_7C55;
                8:       v = 32'h0028_BE53;
                9:       v = 32'h0014_5F2F;
                10:      v = 32'h000A_2F98;
                11:      v = 32'h0005_17CC;
                12:      v = 32'h0002_8BE6;
                13:      v = 32'h0001_45F3;
                14:      v = 32'h0000_A2F9;
                15:      v = 32'h0000_517C;
                16:      v = 32'h0000_28BE;
                17:      v = 32'h0000_145F;
                18:      v = 32'h0000_0A2F;
                19:      v = 32'h0000_0517;
                20:      v = 32'h0000_028B;
                21:      v = 32'h0000_0145;
                22:      v = 32'h0000_00A2;
                23:      v = 32'h0000_0051;
                default: v = 32'h0000_0000;
            endcase
            return v;
        end
    endfunction

    // Round Q30 to Q15 and clamp
    function automatic logic signed [15:0] q15_sat(input logic signed [ROT_W-1:0] v);
        logic signed [ROT_W-1:0] q;
        begin
            q = (v + ROT_W'(16384)) >>> 15;
            if (q > ROT_W'(32767))
                return 16'sh7FFF;
            else if (q < -ROT_W'(32768))
                return 16'sh8000;
            else
                return q[15:0];
        end
    endfunction

endpackage

@@ hdl/tcc_isqrt.sv @@
module tcc_isqrt
    import tcc_pkg::*;
#(
    parameter int PW = 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [SQ_W-1:0]   value,
    input  logic [PW-1:0]     side_in,
    output logic              out_valid,
    output logic [ROOT_W-1:0] root,
    output logic [PW-1:0]     side_out
);

    // One result bit per stage, most significant first
    logic              v_reg    [ROOT_W];
    logic [SQ_W-1:0]   rem_reg  [ROOT_W];
    logic [SQ_W:0]     r_reg    [ROOT_W];
    logic [PW-1:0]     s_reg    [ROOT_W];

    for (genvar j = 0; j < ROOT_W; j++) begin : g_step
        localparam logic [SQ_W:0] BIT = (SQ_W+1)'(1) << (2 * (ROOT_W - 1 - j));
        logic            vi;
        logic [SQ_W-1:0] remi;
        logic [SQ_W:0]   ri;
        logic [PW-1:0]   si;
        logic [SQ_W-1:0] rem_next;
        logic [SQ_W:0]   r_next;
        logic [SQ_W:0]   trial;

        if (j == 0) begin : g_first
            assign vi   = in_valid;
            assign remi = value;
            assign ri   = '0;
            assign si   = side_in;
        end else begin : g_rest
            assign vi   = v_reg[j-1];
            assign remi = rem_reg[j-1];
            assign ri   = r_reg[j-1];
            assign si   = s_reg[j-1];
        end

        always_comb
        begin
            trial = ri + BIT;
            if ({1'b0, remi} >= trial)
            begin
                rem_next = remi - trial[SQ_W-1:0];
                r_next   = (ri >> 1) + BIT;
            end
            else
            begin
                rem_next = remi;
                r_next   = ri >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[j] <= 1'b0;
            else if (en)
                v_reg[j] <= vi;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j] <= rem_next;
                r_reg[j]   <= r_next;
                s_reg[j]   <= si;
            end
        end
    end

    assign out_valid = v_reg[ROOT_W-1];
    assign root      = r_reg[ROOT_W-1][ROOT_W-1:0];
    assign side_out  = s_reg[ROOT_W-1];

endmodule

@@ hdl/tcc_vec.sv @@
module tcc_vec
    import tcc_pkg::*;
#(
    parameter int STEPS = 16,
    parameter int PW    = 1
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic signed [VEC_W-1:0] x_in,
    input  logic signed [VEC_W-1:0] y_in,
    input  logic [PW-1:0]           side_in,
    output logic                    out_valid,
    output logic [ANG_W-1:0]        angle,
    output logic [PW-1:0]           side_out
);

    localparam int NSTP = (STEPS < TAB_LEN) ? STEPS : TAB_LEN;
    localparam int N_RS = 6;
    localparam int N_LS = 5;
    localparam int NN   = 1 + N_RS + N_LS;
    localparam logic signed [NORM_W-1:0] NHI = {{(NORM_W-32){1'b0}}, 32'h8000_0000};
    localparam logic signed [NORM_W-1:0] NLO = {{(NORM_W-32){1'b0}}, 32'h2000_0000};

    // Normalizer stages: half-plane fold, then right and left shift search
    logic                    vn_reg [NN];
    logic                    zr_n_reg [NN];
    logic [31:0]             zn_reg [NN];
    logic signed [NORM_W-1:0] xn_reg [NN];
    logic signed [NORM_W-1:0] yn_reg [NN];
    logic [PW-1:0]           sn_reg [NN];

    logic signed [NORM_W-1:0] xe;
    logic signed [NORM_W-1:0] ye;

    assign xe = NORM_W'(x_in);
    assign ye = NORM_W'(y_in);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vn_reg[0] <= 1'b0;
        else if (en)
            vn_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zr_n_reg[0] <= (xe == '0) && (ye == '0);
            sn_reg[0]   <= side_in;
            if (xe < 0)
            begin
                xn_reg[0] <= -xe;
                yn_reg[0] <= -ye;
                zn_reg[0] <= PI_Z32;
            end
            else
            begin
                xn_reg[0] <= xe;
                yn_reg[0] <= ye;
                zn_reg[0] <= '0;
            end
        end
    end

    for (genvar j = 1; j < NN; j++) begin : g_norm
        localparam int SH = (j <= N_RS) ? (1 << (N_RS - j)) : (1 << (NN - 1 - j));
        logic signed [NORM_W-1:0] tx;
        logic signed [NORM_W-1:0] ty;
        logic signed [NORM_W-1:0] x_nx;
        logic signed [NORM_W-1:0] y_nx;
        logic                     go;

        if (j <= N_RS) begin : g_right
            // shift down while a component is above 2^31
            always_comb
            begin
                tx   = xn_reg[j-1] >>> (SH - 1);
                ty   = yn_reg[j-1] >>> (SH - 1);
                go   = (tx > NHI) || (ty > NHI) || (ty < -NHI);
                x_nx = go ? (xn_reg[j-1] >>> SH) : xn_reg[j-1];
                y_nx = go ? (yn_reg[j-1] >>> SH) : yn_reg[j-1];
            end
        end else begin : g_left
            // shift up while all components are below 2^29
            always_comb
            begin
                tx   = xn_reg[j-1] <<< (SH - 1);
                ty   = yn_reg[j-1] <<< (SH - 1);
                go   = (tx < NLO) && (ty < NLO) && (ty > -NLO);
                x_nx = go ? (xn_reg[j-1] <<< SH) : xn_reg[j-1];
                y_nx = go ? (yn_reg[j-1] <<< SH) : yn_reg[j-1];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vn_reg[j] <= 1'b0;
            else if (en)
                vn_reg[j] <= vn_reg[j-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                xn_reg[j]   <= x_nx;
                yn_reg[j]   <= y_nx;
                zn_reg[j]   <= zn_reg[j-1];
                zr_n_reg[j] <= zr_n_reg[j-1];
                sn_reg[j]   <= sn_reg[j-1];
            end
        end
    end

    // Vectoring iterations, one per stage
    logic                     vc_reg [NSTP];
    logic                     zr_c_reg [NSTP];
    logic [31:0]              zc_reg [NSTP];
    logic signed [CORD_W-1:0] xc_reg [NSTP];
    logic signed [CORD_W-1:0] yc_reg [NSTP];
    logic [PW-1:0]            sc_reg [NSTP];

    for (genvar i = 0; i < NSTP; i++) begin : g_iter
        logic                     vi;
        logic                     zri;
        logic [31:0]              zi;
        logic signed [CORD_W-1:0] xi;
        logic signed [CORD_W-1:0] yi;
        logic [PW-1:0]            si;
        logic signed [CORD_W-1:0] x_nx;
        logic signed [CORD_W-1:0] y_nx;
        logic [31:0]              z_nx;

        if (i == 0) begin : g_first
            assign vi  = vn_reg[NN-1];
            assign zri = zr_n_reg[NN-1];
            assign zi  = zn_reg[NN-1];
            assign xi  = CORD_W'(xn_reg[NN-1]);
            assign yi  = CORD_W'(yn_reg[NN-1]);
            assign si  = sn_reg[NN-1];
        end else begin : g_rest
            assign vi  = vc_reg[i-1];
            assign zri = zr_c_reg[i-1];
            assign zi  = zc_reg[i-1];
            assign xi  = xc_reg[i-1];
            assign yi  = yc_reg[i-1];
            assign si  = sc_reg[i-1];
        end

        always_comb
        begin
            if (!yi[CORD_W-1])
            begin
                x_nx = xi + (yi >>> i);
                y_nx = yi - (xi >>> i);
                z_nx = zi + atan_entry(i);
            end
            else
            begin
                x_nx = xi - (yi >>> i);
                y_nx = yi + (xi >>> i);
                z_nx = zi - atan_entry(i);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vc_reg[i] <= 1'b0;
            else if (en)
                vc_reg[i] <= vi;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                xc_reg[i]   <= x_nx;
                yc_reg[i]   <= y_nx;
                zc_reg[i]   <= z_nx;
                zr_c_reg[i] <= zri;
                sc_reg[i]   <= si;
            end
        end
    end

    // Round to binary angle
    logic             vo_reg;
    logic [ANG_W-1:0] ang_reg;
    logic [PW-1:0]    so_reg;
    logic [31:0]      z_rnd;

    assign z_rnd = zc_reg[NSTP-1] + 32'h0000_8000;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vo_reg <= 1'b0;
        else if (en)
            vo_reg <= vc_reg[NSTP-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ang_reg <= zr_c_reg[NSTP-1] ? '0 : z_rnd[31:16];
            so_reg  <= sc_reg[NSTP-1];
        end
    end

    assign out_valid = vo_reg;
    assign angle     = ang_reg;
    assign side_out  = so_reg;

endmodule

@@ hdl/tcc_rot.sv @@
module tcc_rot
    import tcc_pkg::*;
#(
    parameter int STEPS = 16,
    parameter int PW    = 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [ANG_W-1:0]  angle,
    input  logic [PW-1:0]     side_in,
    output logic              out_valid,
    output logic signed [15:0] sin_q15,
    output logic signed [15:0] cos_q15,
    output logic [PW-1:0]     side_out
);

    localparam int NSTP = (STEPS < TAB_LEN) ? STEPS : TAB_LEN;

    logic                      v_reg [NSTP];
    logic signed [ROT_W-1:0]   x_reg [NSTP];
    logic signed [ROT_W-1:0]   y_reg [NSTP];
    logic signed [ROT_Z_W-1:0] z_reg [NSTP];
    logic [PW-1:0]             s_reg [NSTP];

    // Rotation iterations, one per stage
    for (genvar i = 0; i < NSTP; i++) begin : g_iter
        logic                      vi;
        logic signed [ROT_W-1:0]   xi;
        logic signed [ROT_W-1:0]   yi;
        logic signed [ROT_Z_W-1:0] zi;
        logic [PW-1:0]             si;
        logic signed [ROT_W-1:0]   x_nx;
        logic signed [ROT_W-1:0]   y_nx;
        logic signed [ROT_Z_W-1:0] z_nx;
        logic signed [ROT_Z_W-1:0] at;

        if (i == 0) begin : g_first
            assign vi = in_valid;
            assign xi = INV_GAIN;
            assign yi = '0;
            assign zi = $signed({angle[ANG_W-1], angle, 16'h0000});
            assign si = side_in;
        end else begin : g_rest
            assign vi = v_reg[i-1];
            assign xi = x_reg[i-1];
            assign yi = y_reg[i-1];
            assign zi = z_reg[i-1];
            assign si = s_reg[i-1];
        end

        assign at = $signed({1'b0, atan_entry(i)});

        always_comb
        begin
            if (!zi[ROT_Z_W-1])
            begin
                x_nx = xi - (yi >>> i);
                y_nx = yi + (xi >>> i);
                z_nx = zi - at;
            end
            else
            begin
                x_nx = xi + (yi >>> i);
                y_nx = yi - (xi >>> i);
                z_nx = zi + at;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i] <= 1'b0;
            else if (en)
                v_reg[i] <= vi;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i] <= x_nx;
                y_reg[i] <= y_nx;
                z_reg[i] <= z_nx;
                s_reg[i] <= si;
            end
        end
    end

    // Round to Q1.15
    logic               vo_reg;
    logic signed [15:0] sin_reg;
    logic signed [15:0] cos_reg;
    logic [PW-1:0]      so_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vo_reg <= 1'b0;
        else if (en)
            vo_reg <= v_reg[NSTP-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_reg <= q15_sat(y_reg[NSTP-1]);
            cos_reg <= q15_sat(x_reg[NSTP-1]);
            so_reg  <= s_reg[NSTP-1];
        end
    end

    assign out_valid = vo_reg;
    assign sin_q15   = sin_reg;
    assign cos_q15   = cos_reg;
    assign side_out  = so_reg;

endmodule

@@ hdl/tilt_compensated_compass.sv @@
// Tilt-compensated compass. Each word carries one accelerometer and one
// magnetometer sample (three signed axes each) and yields roll, pitch and
// yaw as 16-bit binary angles (32768 = pi). The datapath is a fully
// pipelined chain: sample capture and squaring (3 stages), a one-bit-per-stage
// square root (17 stages), vectoring CORDIC for roll and pitch side by side
// (CORDIC_STEPS + 13 stages: fold, 11-step normalizing shift search,
// iterations, rounding), rotation CORDIC for their sines and cosines
// (CORDIC_STEPS + 1), three multiply/add stages that tilt the magnetic
// vector, and a final vectoring CORDIC for yaw (CORDIC_STEPS + 13).
// CORDIC_STEPS above 24 act as 24. A new word is taken every cycle; the whole
// pipe holds while a finished word waits on out_ready.
module tilt_compensated_compass
    import tcc_pkg::*;
#(
    parameter int CORDIC_STEPS = 16,
    parameter int SAMPLE_BITS  = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [FIELD_W-1:0] accel_x,
    input  logic signed [FIELD_W-1:0] accel_y,
    input  logic signed [FIELD_W-1:0] accel_z,
    input  logic signed [FIELD_W-1:0] mag_x,
    input  logic signed [FIELD_W-1:0] mag_y,
    input  logic signed [FIELD_W-1:0] mag_z,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [ANG_W-1:0]   roll_angle,
    output logic signed [ANG_W-1:0]   pitch_angle,
    output logic signed [ANG_W-1:0]   yaw_angle
);

    localparam int SB   = (SAMPLE_BITS > FIELD_W) ? FIELD_W : SAMPLE_BITS;
    localparam bit WIDE = (SAMPLE_BITS > FIELD_W);
    localparam logic [ANG_W-1:0] ROLL_UP = 16'h4000;
    localparam logic [ANG_W-1:0] ROLL_DN = 16'hC000;
    localparam int IMU_W = $bits(imu_t);
    localparam int RV_PW = 3 + 2 * SMP_W;
    localparam int RR_PW = ANG_W + 2 * SMP_W;
    localparam int PR_PW = ANG_W + SMP_W;
    localparam int M1_W  = 2 * SMP_W - 1;
    localparam int M2_W  = 50;

    // Whole pipe advances unless a result is stuck at the output
    logic en;
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    // Extraction: low SAMPLE_BITS bits sign-extended; zero-extended if wider
    function automatic smp_t take(input logic [FIELD_W-1:0] f);
        logic [FIELD_W-1:0] m;
        begin
            for (int b = 0; b < FIELD_W; b++)
                m[b] = (b < SB) ? f[b] : f[SB-1];
            if (WIDE)
                return $signed({1'b0, f});
            else
                return $signed({m[FIELD_W-1], m});
        end
    endfunction

    // Stage A: capture
    logic va_reg;
    imu_t a_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            va_reg <= 1'b0;
        else if (en)
            va_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg.ax <= take(accel_x);
            a_reg.ay <= take(accel_y);
            a_reg.az <= take(accel_z);
            a_reg.mx <= take(mag_x);
            a_reg.my <= take(mag_y);
            a_reg.mz <= take(mag_z);
        end
    end

    // Stage B: squares
    logic vb_reg;
    imu_t b_reg;
    logic [SQ_W-1:0] sqy_reg;
    logic [SQ_W-1:0] sqz_reg;
    logic signed [2*SMP_W-1:0] py;
    logic signed [2*SMP_W-1:0] pz;

    assign py = $signed(a_reg.ay) * $signed(a_reg.ay);
    assign pz = $signed(a_reg.az) * $signed(a_reg.az);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vb_reg <= 1'b0;
        else if (en)
            vb_reg <= va_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_reg   <= a_reg;
            sqy_reg <= SQ_W'(py);
            sqz_reg <= SQ_W'(pz);
        end
    end

    // Stage C: sum of squares
    logic vc_reg;
    imu_t c_reg;
    logic [SQ_W-1:0] sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vc_reg <= 1'b0;
        else if (en)
            vc_reg <= vb_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg   <= b_reg;
            sum_reg <= sqy_reg + sqz_reg;
        end
    end

    // Square root of ay^2 + az^2
    logic              vs;
    logic [ROOT_W-1:0] root_s;
    logic [IMU_W-1:0]  side_s;
    imu_t              imu_s;

    tcc_isqrt #(
        .PW (IMU_W)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vc_reg),
        .value     (sum_reg),
        .side_in   (c_reg),
        .out_valid (vs),
        .root      (root_s),
        .side_out  (side_s)
    );

    assign imu_s = imu_t'(side_s);

    // Roll and pitch angles
    logic signed [VEC_W-1:0] roll_x;
    logic signed [VEC_W-1:0] roll_y;
    logic signed [VEC_W-1:0] pitch_x;
    logic signed [VEC_W-1:0] pitch_y;
    logic [RV_PW-1:0]        roll_side_in;
    logic [SMP_W-1:0]        pitch_side_in;
    logic                    az_neg;

    assign az_neg  = imu_s.az[SMP_W-1];
    assign roll_x  = az_neg ? -VEC_W'($signed(imu_s.az)) : VEC_W'($signed(imu_s.az));
    assign roll_y  = az_neg ? -VEC_W'($signed(imu_s.ay)) : VEC_W'($signed(imu_s.ay));
    assign pitch_x = $signed({{(VEC_W-ROOT_W){1'b0}}, root_s});
    assign pitch_y = VEC_W'($signed(imu_s.ax));
    assign roll_side_in = {(imu_s.az == '0),
                           (!imu_s.ay[SMP_W-1] && (imu_s.ay != '0)),
                           imu_s.ay[SMP_W-1],
                           imu_s.mx,
                           imu_s.my};
    assign pitch_side_in = imu_s.mz;

    logic             vr;
    logic             vp;
    logic [ANG_W-1:0] roll_v;
    logic [ANG_W-1:0] pitch_v;
    logic [RV_PW-1:0] roll_side;
    logic [SMP_W-1:0] pitch_side;

    tcc_vec #(
        .STEPS (CORDIC_STEPS),
        .PW    (RV_PW)
    ) u_roll_vec (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vs),
        .x_in      (roll_x),
        .y_in      (roll_y),
        .side_in   (roll_side_in),
        .out_valid (vr),
        .angle     (roll_v),
        .side_out  (roll_side)
    );

    tcc_vec #(
        .STEPS (CORDIC_STEPS),
        .PW    (SMP_W)
    ) u_pitch_vec (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vs),
        .x_in      (pitch_x),
        .y_in      (pitch_y),
        .side_in   (pitch_side_in),
        .out_valid (vp),
        .angle     (pitch_v),
        .side_out  (pitch_side)
    );

    // Roll with flat accelerometer z
    logic [ANG_W-1:0] roll_sel;
    always_comb
    begin
        if (roll_side[RV_PW-1])
        begin
            if (roll_side[RV_PW-2])
                roll_sel = ROLL_UP;
            else if (roll_side[RV_PW-3])
                roll_sel = ROLL_DN;
            else
                roll_sel = '0;
        end
        else
        begin
            roll_sel = roll_v;
        end
    end

    // Sines and cosines of roll and pitch
    logic               vrr;
    logic               vpr;
    logic signed [15:0] sr;
    logic signed [15:0] cr;
    logic signed [15:0] sp;
    logic signed [15:0] cp;
    logic [RR_PW-1:0]   rr_side;
    logic [PR_PW-1:0]   pr_side;

    tcc_rot #(
        .STEPS (CORDIC_STEPS),
        .PW    (RR_PW)
    ) u_roll_rot (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vr && vp),
        .angle     (roll_sel),
        .side_in   ({roll_sel, roll_side[2*SMP_W-1:0]}),
        .out_valid (vrr),
        .sin_q15   (sr),
        .cos_q15   (cr),
        .side_out  (rr_side)
    );

    tcc_rot #(
        .STEPS (CORDIC_STEPS),
        .PW    (PR_PW)
    ) u_pitch_rot (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vr && vp),
        .angle     (pitch_v),
        .side_in   ({pitch_v, pitch_side}),
        .out_valid (vpr),
        .sin_q15   (sp),
        .cos_q15   (cp),
        .side_out  (pr_side)
    );

    smp_t mx_r;
    smp_t my_r;
    smp_t mz_r;
    assign mx_r = $signed(rr_side[2*SMP_W-1:SMP_W]);
    assign my_r = $signed(rr_side[SMP_W-1:0]);
    assign mz_r = $signed(pr_side[SMP_W-1:0]);

    // M1: first products
    logic                   vm1_reg;
    logic signed [M1_W-1:0] cp_mx_reg;
    logic signed [31:0]     sp_sr_reg;
    logic signed [31:0]     sp_cr_reg;
    logic signed [M1_W-1:0] cr_my_reg;
    logic signed [M1_W-1:0] sr_mz_reg;
    smp_t                   my_m1_reg;
    smp_t                   mz_m1_reg;
    logic [ANG_W-1:0]       roll_m1_reg;
    logic [ANG_W-1:0]       pitch_m1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vm1_reg <= 1'b0;
        else if (en)
            vm1_reg <= vrr && vpr;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cp_mx_reg    <= cp * mx_r;
            sp_sr_reg    <= sp * sr;
            sp_cr_reg    <= sp * cr;
            cr_my_reg    <= cr * my_r;
            sr_mz_reg    <= sr * mz_r;
            my_m1_reg    <= my_r;
            mz_m1_reg    <= mz_r;
            roll_m1_reg  <= rr_side[RR_PW-1:2*SMP_W];
            pitch_m1_reg <= pr_side[PR_PW-1:SMP_W];
        end
    end

    // M2: second products and second tilted component
    logic                   vm2_reg;
    logic signed [M2_W-1:0] t1_reg;
    logic signed [M2_W-1:0] t2_reg;
    logic signed [M2_W-1:0] t3_reg;
    logic signed [M2_W-1:0] w1_reg;
    logic [ANG_W-1:0]       roll_m2_reg;
    logic [ANG_W-1:0]       pitch_m2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vm2_reg <= 1'b0;
        else if (en)
            vm2_reg <= vm1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_reg       <= M2_W'(cp_mx_reg) <<< 15;
            t2_reg       <= sp_sr_reg * my_m1_reg;
            t3_reg       <= sp_cr_reg * mz_m1_reg;
            w1_reg       <= (M2_W'(cr_my_reg) - M2_W'(sr_mz_reg)) <<< 15;
            roll_m2_reg  <= roll_m1_reg;
            pitch_m2_reg <= pitch_m1_reg;
        end
    end

    // M3: first tilted component, negated
    logic                    vm3_reg;
    logic signed [VEC_W-1:0] nw0_reg;
    logic signed [VEC_W-1:0] w1e_reg;
    logic [ANG_W-1:0]        roll_m3_reg;
    logic [ANG_W-1:0]        pitch_m3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vm3_reg <= 1'b0;
        else if (en)
            vm3_reg <= vm2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nw0_reg      <= -(VEC_W'(t1_reg) + VEC_W'(t2_reg) + VEC_W'(t3_reg));
            w1e_reg      <= VEC_W'(w1_reg);
            roll_m3_reg  <= roll_m2_reg;
            pitch_m3_reg <= pitch_m2_reg;
        end
    end

    // Yaw
    logic               vy;
    logic [ANG_W-1:0]   yaw_v;
    logic [2*ANG_W-1:0] yaw_side;

    tcc_vec #(
        .STEPS (CORDIC_STEPS),
        .PW    (2 * ANG_W)
    ) u_yaw_vec (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vm3_reg),
        .x_in      (w1e_reg),
        .y_in      (nw0_reg),
        .side_in   ({roll_m3_reg, pitch_m3_reg}),
        .out_valid (vy),
        .angle     (yaw_v),
        .side_out  (yaw_side)
    );

    assign out_valid   = vy;
    assign roll_angle  = $signed(yaw_side[2*ANG_W-1:ANG_W]);
    assign pitch_angle = $signed(yaw_side[ANG_W-1:0]);
    assign yaw_angle   = $signed(yaw_v);

endmodule

@@ hdl/tcc_check.sv @@
module tcc_check
    import tcc_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_ready,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic signed [ANG_W-1:0] roll_angle,
    input logic signed [ANG_W-1:0] pitch_angle
);

    // Stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(roll_angle) && $stable(pitch_angle))
        else $error("output word changed while stalled");

    // Back-pressure reaches the input
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while output stalled");

    // Empty output never blocks the input
    a_free_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

    // Roll and pitch stay within a half circle
    a_tilt_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (roll_angle >= -16'sd16384) && (roll_angle <= 16'sd16384)
                   && (pitch_angle >= -16'sd16384) && (pitch_angle <= 16'sd16384))
        else $error("tilt angle out of range");

endmodule

bind tilt_compensated_compass tcc_check u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .roll_angle  (roll_angle),
    .pitch_angle (pitch_angle)
);
